// File: design/owb_pkg.sv
package owb_pkg;

  // Timer and field widths
  localparam int TimerWidth = 10;
  localparam int NumRegs    = 8;
  localparam int RegIdxW    = 3;
  localparam int ByteW      = 8;
  localparam int BitPosW    = 3;

  typedef logic [TimerWidth-1:0] tick_t;
  typedef logic [ByteW-1:0]      byte_t;

  // Command codes carried by op
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // Timing register indexes
  typedef enum logic [RegIdxW-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_WR1_LOW       = 3'd3,
    REG_WR1_RELEASE   = 3'd4,
    REG_WR0_LOW       = 3'd5,
    REG_READ_LOW      = 3'd6,
    REG_READ_TAIL     = 3'd7
  } reg_idx_t;

  typedef tick_t cfg_t [NumRegs];

  // Register values after reset, by index
  localparam tick_t CfgReset [NumRegs] = '{
    10'd480, 10'd80, 10'd400, 10'd1, 10'd60, 10'd60, 10'd2, 10'd60
  };

  // Bus sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RST_LOW  = 3'd1,
    PH_RST_WAIT = 3'd2,
    PH_RST_TAIL = 3'd3,
    PH_WR_LOW   = 3'd4,
    PH_WR_REL   = 3'd5,
    PH_RD_LOW   = 3'd6,
    PH_RD_TAIL  = 3'd7
  } phase_t;

  localparam logic [BitPosW-1:0] LastBit = BitPosW'(ByteW - 1);

  typedef struct packed {
    phase_t              phase;
    tick_t               tick_count;
    logic [BitPosW-1:0]  bit_position;
    byte_t               shift_byte;
    logic                presence_seen;
    byte_t               read_result;
  } state_t;

  typedef struct packed {
    logic  drive_low;
    logic  busy_res;
    logic  done_res;
    logic  presence;
    byte_t rx_byte;
    logic  command_ignored;
  } result_t;

  // Last tick of a timed phase lasting max(t,1) ticks
  function automatic logic timed_end(tick_t tc, tick_t t);
    return ({1'b0, tc} + {{TimerWidth{1'b0}}, 1'b1}) >= {1'b0, t};
  endfunction

  // Last tick of a sample tick followed by t more ticks
  function automatic logic tail_end(tick_t tc, tick_t t);
    return tc >= t;
  endfunction

endpackage

// File: design/owb_ifs.sv
// Command tick channel
interface owb_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  owb_pkg::byte_t     tx_byte;
  logic               line_level;

  modport source (output valid, op, tx_byte, line_level, input ready);
  modport sink   (input valid, op, tx_byte, line_level, output ready);
endinterface

// Per-tick result channel
interface owb_res_if;
  logic               valid;
  logic               ready;
  logic               drive_low;
  logic               busy_res;
  logic               done_res;
  logic               presence;
  owb_pkg::byte_t     rx_byte;
  logic               command_ignored;

  modport source (output valid, drive_low, busy_res, done_res, presence, rx_byte,
                  command_ignored, input ready);
  modport sink   (input valid, drive_low, busy_res, done_res, presence, rx_byte,
                  command_ignored, output ready);
endinterface

// File: design/one_wire_bus_master.sv
// Single-wire bus master, stepped once per microsecond tick.
// cmd: one transfer per tick carrying op (tick, reset, write byte, read byte),
//   tx_byte and the sampled line level. A command while busy is dropped and
//   reported in command_ignored; the running operation goes on.
// res: one transfer per accepted tick with drive_low for that tick, busy,
//   done, the latest presence flag and the last byte read.
// Timing registers are written through wr_en/wr_index/wr_data; write them only while
//   the bus is idle and no results are pending (the block does not enforce it).
// Latency: the result of a tick is valid the cycle after its cmd transfer.
// Throughput: one tick per cycle unless the receiver stalls; the sequencer
//   state and the result register both update in the accepting cycle,
//   through one pass of the phase/timer logic.
// Stall: cmd.ready is high while the result register is empty or is being
//   drained, so a stalled receiver holds the result and stops intake,
//   which also stops the sequencer.
// Reset (rst, synchronous): sequencer idle, presence and rx_byte cleared,
//   timing registers back to their defaults, no result pending.
module one_wire_bus_master (
  input  logic                          clk,
  input  logic                          rst,
  owb_cmd_if.sink                       cmd,
  owb_res_if.source                     res,
  input  logic                          wr_en,
  input  logic [owb_pkg::RegIdxW-1:0]   wr_index,
  input  owb_pkg::tick_t                wr_data
);

  owb_pkg::cfg_t    cfg;
  owb_pkg::state_t  state;
  owb_pkg::state_t  state_next;
  owb_pkg::result_t result_next;
  owb_pkg::result_t result;
  logic             res_valid;
  logic             take;

  // Timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= owb_pkg::CfgReset;
    end else if (wr_en) begin
      cfg[wr_index] <= wr_data;
    end
  end

  owb_step u_step (
    .cur        (state),
    .cfg        (cfg),
    .op         (cmd.op),
    .tx_byte    (cmd.tx_byte),
    .line_level (cmd.line_level),
    .nxt        (state_next),
    .res        (result_next)
  );

  assign cmd.ready = !res_valid || res.ready;
  assign take      = cmd.valid && cmd.ready;

  // Sequencer state advances one tick per transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: owb_pkg::PH_IDLE, default: '0};
    end else if (take) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

  assign res.valid           = res_valid;
  assign res.drive_low       = result.drive_low;
  assign res.busy_res        = result.busy_res;
  assign res.done_res        = result.done_res;
  assign res.presence        = result.presence;
  assign res.rx_byte         = result.rx_byte;
  assign res.command_ignored = result.command_ignored;

endmodule

// File: design/owb_step.sv
// One tick of the bus sequencer: next state and the result for this tick
module owb_step (
  input  owb_pkg::state_t  cur,
  input  owb_pkg::cfg_t    cfg,
  input  logic [1:0]       op,
  input  owb_pkg::byte_t   tx_byte,
  input  logic             line_level,
  output owb_pkg::state_t  nxt,
  output owb_pkg::result_t res
);

  owb_pkg::op_t    op_code;
  owb_pkg::state_t st;
  owb_pkg::tick_t  lim;
  logic            is_tail;
  logic            last;
  logic            ignored;
  logic            drive;
  logic            done;

  assign op_code = owb_pkg::op_t'(op);

  always_comb begin
    st      = cur;
    ignored = 1'b0;
    drive   = 1'b0;
    done    = 1'b0;
    lim     = '0;
    is_tail = 1'b0;

    // Command decode: start from idle, flag when busy
    if (cur.phase != owb_pkg::PH_IDLE) begin
      ignored = (op_code != owb_pkg::OP_TICK);
    end else begin
      case (op_code)
        owb_pkg::OP_RESET: begin
          st.bit_position = '0;
          st.tick_count   = '0;
          st.phase        = owb_pkg::PH_RST_LOW;
        end
        owb_pkg::OP_WRITE: begin
          st.bit_position = '0;
          st.tick_count   = '0;
          st.shift_byte   = tx_byte;
          st.phase        = owb_pkg::PH_WR_LOW;
        end
        owb_pkg::OP_READ: begin
          st.bit_position = '0;
          st.tick_count   = '0;
          st.shift_byte   = '0;
          st.phase        = owb_pkg::PH_RD_LOW;
        end
        default: ;
      endcase
    end

    // Phase limit selection
    case (st.phase)
      owb_pkg::PH_RST_LOW:  lim = cfg[owb_pkg::REG_RESET_LOW];
      owb_pkg::PH_RST_WAIT: lim = cfg[owb_pkg::REG_PRESENCE_WAIT];
      owb_pkg::PH_RST_TAIL: begin
        lim     = cfg[owb_pkg::REG_RESET_TAIL];
        is_tail = 1'b1;
      end
      owb_pkg::PH_WR_LOW:
        lim = st.shift_byte[0] ? cfg[owb_pkg::REG_WR1_LOW] : cfg[owb_pkg::REG_WR0_LOW];
      owb_pkg::PH_WR_REL:   lim = cfg[owb_pkg::REG_WR1_RELEASE];
      owb_pkg::PH_RD_LOW:   lim = cfg[owb_pkg::REG_READ_LOW];
      owb_pkg::PH_RD_TAIL: begin
        lim     = cfg[owb_pkg::REG_READ_TAIL];
        is_tail = 1'b1;
      end
      default: ;
    endcase

    last = is_tail ? owb_pkg::tail_end(st.tick_count, lim)
                   : owb_pkg::timed_end(st.tick_count, lim);

    // Phase actions and transitions
    case (st.phase)
      owb_pkg::PH_RST_LOW: begin
        drive = 1'b1;
        if (last) st.phase = owb_pkg::PH_RST_WAIT;
      end
      owb_pkg::PH_RST_WAIT: begin
        if (last) st.phase = owb_pkg::PH_RST_TAIL;
      end
      owb_pkg::PH_RST_TAIL: begin
        if (st.tick_count == '0) st.presence_seen = ~line_level;
        if (last) begin
          st.phase = owb_pkg::PH_IDLE;
          done     = 1'b1;
        end
      end
      owb_pkg::PH_WR_LOW, owb_pkg::PH_WR_REL: begin
        drive = (st.phase == owb_pkg::PH_WR_LOW);
        if (last) begin
          if (st.phase == owb_pkg::PH_WR_LOW && st.shift_byte[0]) begin
            st.phase = owb_pkg::PH_WR_REL;
          end else begin
            // slot finished: next bit or done
            st.shift_byte = st.shift_byte >> 1;
            if (st.bit_position == owb_pkg::LastBit) begin
              st.phase = owb_pkg::PH_IDLE;
              done     = 1'b1;
            end else begin
              st.bit_position = st.bit_position + 1'b1;
              st.phase        = owb_pkg::PH_WR_LOW;
            end
          end
        end
      end
      owb_pkg::PH_RD_LOW: begin
        drive = 1'b1;
        if (last) st.phase = owb_pkg::PH_RD_TAIL;
      end
      owb_pkg::PH_RD_TAIL: begin
        if (st.tick_count == '0) st.shift_byte = {line_level, st.shift_byte[7:1]};
        if (last) begin
          if (st.bit_position == owb_pkg::LastBit) begin
            st.read_result = st.shift_byte;
            st.phase       = owb_pkg::PH_IDLE;
            done           = 1'b1;
          end else begin
            st.bit_position = st.bit_position + 1'b1;
            st.phase        = owb_pkg::PH_RD_LOW;
          end
        end
      end
      default: ;
    endcase

    // Every phase end restarts the tick counter
    if (st.phase != owb_pkg::PH_IDLE || done) begin
      st.tick_count = last ? '0 : st.tick_count + 1'b1;
    end

    nxt                 = st;
    res.drive_low       = drive;
    res.busy_res        = (st.phase != owb_pkg::PH_IDLE);
    res.done_res        = done;
    res.presence        = st.presence_seen;
    res.rx_byte         = st.read_result;
    res.command_ignored = ignored;
  end

endmodule

// File: tb/tb.sv
module tb;

  localparam int RandItems  = 850;
  localparam int HoldCycles = 60;
  localparam int StallLimit = 2000;

  // Typed expectations for the directed table
  localparam owb_pkg::result_t QuietTick = '0;
  localparam owb_pkg::result_t ResetOpen = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
  localparam owb_pkg::result_t BusyDrop  = '{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 1'b1};

  typedef struct {
    logic             is_cfg;   // load every timing register with fill, block idle
    owb_pkg::tick_t   fill;
    owb_pkg::op_t     op;
    owb_pkg::byte_t   tx;
    logic             lvl;
    logic             run_out;  // keep ticking at lvl until the operation ends
    logic             typed;
    owb_pkg::result_t want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  logic [owb_pkg::RegIdxW-1:0] wr_index;
  owb_pkg::tick_t wr_data;

  owb_cmd_if cmd_ch ();
  owb_res_if res_ch ();

  one_wire_bus_master dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_ch),
    .res      (res_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #6 clk = ~clk;

  // Bus sequencer mirror, owned by the stimulus process
  owb_pkg::phase_t             seq_phase;
  owb_pkg::tick_t              slot_ticks;
  logic [owb_pkg::BitPosW-1:0] bit_idx;
  owb_pkg::byte_t              shift_q;
  logic                        presence_q;
  owb_pkg::byte_t              rx_q;
  owb_pkg::cfg_t               timing_q;

  owb_pkg::result_t predicted_q [$];

  int  mismatches   = 0;
  int  ticks_sent   = 0;
  int  rand_start   = 1 << 30;
  int  ops_done     = 0;
  int  drops_seen   = 0;
  int  settings_cnt = 0;
  int  tx_idle_pct  = 13;
  int  rx_idle_pct  = 64;
  int  quiet_cycles = 0;
  bit  hold_req     = 1'b0;
  bit  hold_done    = 1'b0;
  bit  pause_done   = 1'b0;

  task automatic note_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("ERROR @%0t: %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void enter_phase(owb_pkg::phase_t p);
    seq_phase  = p;
    slot_ticks = '0;
  endfunction

  // Timed phase lasting max(lim,1) ticks; true on its last tick
  function automatic logic span_over(owb_pkg::tick_t lim);
    if (int'(slot_ticks) + 1 >= int'(lim)) return 1'b1;
    slot_ticks = slot_ticks + 1'b1;
    return 1'b0;
  endfunction

  // Sample tick followed by lim more ticks; true on the last one
  function automatic logic tail_over(owb_pkg::tick_t lim);
    if (slot_ticks >= lim) return 1'b1;
    slot_ticks = slot_ticks + 1'b1;
    return 1'b0;
  endfunction

  // Shift out the sent bit; true when the byte is complete
  function automatic logic write_bit_over();
    shift_q = shift_q >> 1;
    if (bit_idx == owb_pkg::LastBit) return 1'b1;
    bit_idx = bit_idx + 1'b1;
    enter_phase(owb_pkg::PH_WR_LOW);
    return 1'b0;
  endfunction

  // One microsecond tick of the bus master
  function automatic owb_pkg::result_t bus_tick(owb_pkg::op_t op, owb_pkg::byte_t tx,
                                                logic lvl);
    owb_pkg::result_t r;
    logic    drv;
    logic    dropped;
    logic    fin;
    logic    b;
    drv = 1'b0;
    dropped = 1'b0;
    fin = 1'b0;
    if (seq_phase != owb_pkg::PH_IDLE) begin
      dropped = (op != owb_pkg::OP_TICK);
    end else if (op != owb_pkg::OP_TICK) begin
      bit_idx = '0;
      case (op)
        owb_pkg::OP_RESET: enter_phase(owb_pkg::PH_RST_LOW);
        owb_pkg::OP_WRITE: begin
          shift_q = tx;
          enter_phase(owb_pkg::PH_WR_LOW);
        end
        default: begin
          shift_q = '0;
          enter_phase(owb_pkg::PH_RD_LOW);
        end
      endcase
    end
    case (seq_phase)
      owb_pkg::PH_RST_LOW: begin
        drv = 1'b1;
        if (span_over(timing_q[owb_pkg::REG_RESET_LOW]))
          enter_phase(owb_pkg::PH_RST_WAIT);
      end
      owb_pkg::PH_RST_WAIT: begin
        if (span_over(timing_q[owb_pkg::REG_PRESENCE_WAIT]))
          enter_phase(owb_pkg::PH_RST_TAIL);
      end
      owb_pkg::PH_RST_TAIL: begin
        if (slot_ticks == '0) presence_q = ~lvl;
        fin = tail_over(timing_q[owb_pkg::REG_RESET_TAIL]);
      end
      owb_pkg::PH_WR_LOW: begin
        drv = 1'b1;
        b = shift_q[0];
        if (span_over(b ? timing_q[owb_pkg::REG_WR1_LOW]
                        : timing_q[owb_pkg::REG_WR0_LOW])) begin
          if (b) enter_phase(owb_pkg::PH_WR_REL);
          else fin = write_bit_over();
        end
      end
      owb_pkg::PH_WR_REL: begin
        if (span_over(timing_q[owb_pkg::REG_WR1_RELEASE])) fin = write_bit_over();
      end
      owb_pkg::PH_RD_LOW: begin
        drv = 1'b1;
        if (span_over(timing_q[owb_pkg::REG_READ_LOW]))
          enter_phase(owb_pkg::PH_RD_TAIL);
      end
      owb_pkg::PH_RD_TAIL: begin
        if (slot_ticks == '0) shift_q = {lvl, shift_q[owb_pkg::ByteW-1:1]};
        if (tail_over(timing_q[owb_pkg::REG_READ_TAIL])) begin
          if (bit_idx == owb_pkg::LastBit) begin
            rx_q = shift_q;
            fin = 1'b1;
          end else begin
            bit_idx = bit_idx + 1'b1;
            enter_phase(owb_pkg::PH_RD_LOW);
          end
        end
      end
      default: ;
    endcase
    if (fin) enter_phase(owb_pkg::PH_IDLE);
    r.drive_low       = drv;
    r.busy_res        = (seq_phase != owb_pkg::PH_IDLE);
    r.done_res        = fin;
    r.presence        = presence_q;
    r.rx_byte         = rx_q;
    r.command_ignored = dropped;
    return r;
  endfunction

  // Offer one tick on the command channel and record what it must produce
  task automatic send_item(owb_pkg::op_t op, owb_pkg::byte_t tx, logic lvl, logic typed,
                           owb_pkg::result_t want);
    owb_pkg::result_t got;
    if (ticks_sent >= rand_start + 2 * RandItems / 3) begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end else if (ticks_sent >= rand_start + RandItems / 3) begin
      tx_idle_pct = 64;
      rx_idle_pct = 13;
    end
    if ($urandom_range(99) < tx_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.op         <= op;
    cmd_ch.tx_byte    <= tx;
    cmd_ch.line_level <= lvl;
    do @(posedge clk); while (!cmd_ch.ready);
    got = bus_tick(op, tx, lvl);
    predicted_q.push_back(typed ? want : got);
    ticks_sent++;
  endtask

  // Load all timing registers once the block is idle and drained
  task automatic load_timing(input owb_pkg::cfg_t vals);
    cmd_ch.valid <= 1'b0;
    while (predicted_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    foreach (vals[i]) begin
      wr_en    <= 1'b1;
      wr_index <= owb_pkg::RegIdxW'(i);
      wr_data  <= vals[i];
      @(posedge clk);
      timing_q[i] = vals[i];
    end
    wr_en <= 1'b0;
    settings_cnt++;
  endtask

  // Plain tick with random level; sometimes a stray command
  task automatic random_tick(int noise_pct);
    owb_pkg::op_t op;
    op = owb_pkg::OP_TICK;
    if ($urandom_range(99) < noise_pct) op = owb_pkg::op_t'($urandom_range(1, 3));
    // long receiver hold while ticks keep coming
    if (!hold_done && ticks_sent - rand_start >= 200) begin
      hold_done = 1'b1;
      hold_req  = 1'b1;
    end
    // sender pause until every result is back
    if (!pause_done && ticks_sent - rand_start >= 700) begin
      pause_done = 1'b1;
      cmd_ch.valid <= 1'b0;
      do @(posedge clk); while (predicted_q.size() != 0);
    end
    send_item(op, owb_pkg::byte_t'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
  endtask

  task automatic run_random_op();
    owb_pkg::op_t op;
    op = owb_pkg::op_t'($urandom_range(1, 3));
    send_item(op, owb_pkg::byte_t'($urandom), 1'($urandom_range(0, 1)), 1'b0, '0);
    while (seq_phase != owb_pkg::PH_IDLE) random_tick(8);
    repeat ($urandom_range(0, 2)) random_tick(0);
  endtask

  // Result receiver: random backpressure plus one long hold on request
  initial begin : receiver
    res_ch.ready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        @(posedge clk);
      end
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    owb_pkg::result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (predicted_q.size() == 0) begin
        note_mismatch("result with nothing expected", 8'h00, 8'h00);
      end else begin
        want = predicted_q.pop_front();
        if (res_ch.drive_low !== want.drive_low)
          note_mismatch("drive_low", 8'(res_ch.drive_low), 8'(want.drive_low));
        if (res_ch.busy_res !== want.busy_res)
          note_mismatch("busy_res", 8'(res_ch.busy_res), 8'(want.busy_res));
        if (res_ch.done_res !== want.done_res)
          note_mismatch("done_res", 8'(res_ch.done_res), 8'(want.done_res));
        if (res_ch.presence !== want.presence)
          note_mismatch("presence", 8'(res_ch.presence), 8'(want.presence));
        if (res_ch.rx_byte !== want.rx_byte)
          note_mismatch("rx_byte", res_ch.rx_byte, want.rx_byte);
        if (res_ch.command_ignored !== want.command_ignored)
          note_mismatch("command_ignored", 8'(res_ch.command_ignored),
                        8'(want.command_ignored));
        ops_done   += int'(want.done_res);
        drops_seen += int'(want.command_ignored);
      end
    end
  end

  // Watchdog: too long without any transfer
  always @(posedge clk) begin : watchdog
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("ERROR: no transfer for %0d cycles", quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    script_row_t script [15] = '{
      '{1'b0, 10'd0, owb_pkg::OP_TICK,  8'hFF, 1'b1, 1'b0, 1'b1, QuietTick},
      '{1'b0, 10'd0, owb_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 1'b1, QuietTick},
      '{1'b1, 10'd0, owb_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 1'b0, QuietTick},
      '{1'b0, 10'd0, owb_pkg::OP_RESET, 8'h00, 1'b1, 1'b0, 1'b1, ResetOpen},
      '{1'b0, 10'd0, owb_pkg::OP_READ,  8'hFF, 1'b0, 1'b0, 1'b1, BusyDrop},
      // command on the finishing tick of the reset, device present
      '{1'b0, 10'd0, owb_pkg::OP_WRITE, 8'h5A, 1'b0, 1'b0, 1'b0, QuietTick},
      '{1'b0, 10'd0, owb_pkg::OP_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0, QuietTick},
      '{1'b0, 10'd0, owb_pkg::OP_WRITE, 8'h00, 1'b0, 1'b1, 1'b0, QuietTick},
      '{1'b0, 10'd0, owb_pkg::OP_READ,  8'h00, 1'b1, 1'b1, 1'b0, QuietTick},
      '{1'b0, 10'd0, owb_pkg::OP_READ,  8'hFF, 1'b0, 1'b1, 1'b0, QuietTick},
      '{1'b0, 10'd0, owb_pkg::OP_RESET, 8'h00, 1'b1, 1'b1, 1'b0, QuietTick},
      // long timings on every register
      '{1'b1, 10'd8, owb_pkg::OP_TICK,  8'h00, 1'b0, 1'b0, 1'b0, QuietTick},
      '{1'b0, 10'd0, owb_pkg::OP_RESET, 8'h00, 1'b0, 1'b1, 1'b0, QuietTick},
      '{1'b0, 10'd0, owb_pkg::OP_WRITE, 8'h80, 1'b1, 1'b1, 1'b0, QuietTick},
      '{1'b0, 10'd0, owb_pkg::OP_READ,  8'h00, 1'b0, 1'b1, 1'b0, QuietTick}
    };
    owb_pkg::cfg_t vals;
    int   setting;

    rst               = 1'b1;
    wr_en             = 1'b0;
    wr_index          = '0;
    wr_data           = '0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.op         = owb_pkg::OP_TICK;
    cmd_ch.tx_byte    = '0;
    cmd_ch.line_level = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    timing_q   = owb_pkg::CfgReset;
    seq_phase  = owb_pkg::PH_IDLE;
    slot_ticks = '0;
    bit_idx    = '0;
    shift_q    = '0;
    presence_q = 1'b0;
    rx_q       = '0;

    // Directed table
    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        foreach (vals[j]) vals[j] = script[i].fill;
        load_timing(vals);
      end else begin
        send_item(script[i].op, script[i].tx, script[i].lvl, script[i].typed,
                  script[i].want);
        if (script[i].run_out)
          while (seq_phase != owb_pkg::PH_IDLE)
            send_item(owb_pkg::OP_TICK, owb_pkg::byte_t'($urandom), script[i].lvl,
                      1'b0, '0);
      end
    end

    // Random operations under a series of timing settings
    rand_start = ticks_sent;
    setting = 0;
    while (ticks_sent - rand_start < RandItems) begin
      foreach (vals[j]) begin
        case (setting % 3)
          0: vals[j] = owb_pkg::tick_t'($urandom_range(0, 3));
          1: vals[j] = owb_pkg::tick_t'($urandom_range(0, 12));
          default: vals[j] = (j <= owb_pkg::REG_RESET_TAIL)
                             ? owb_pkg::tick_t'($urandom_range(0, 60))
                             : owb_pkg::tick_t'($urandom_range(0, 6));
        endcase
      end
      if (setting == 1) vals = owb_pkg::CfgReset;
      load_timing(vals);
      for (int k = 0; k < ((setting == 1) ? 1 : 10); k++)
        if (ticks_sent - rand_start < RandItems) run_random_op();
      setting++;
    end

    cmd_ch.valid <= 1'b0;
    while (predicted_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (predicted_q.size() != 0)
      note_mismatch("results never delivered", 8'h00, 8'(predicted_q.size()));

    $display("Run covered %0d ticks over %0d timing settings (all zero, long, short, defaults)",
             ticks_sent, settings_cnt);
    $display("%0d operations completed, %0d commands dropped while busy, %0d mismatches",
             ops_done, drops_seen, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
